// ----- rtl/core/intrusion_alarm_controller_defines.svh -----
// ----------------------------------------------------------------------------
// Intrusion alarm controller assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef INTRUSION_ALARM_CONTROLLER_DEFINES_SVH
`define INTRUSION_ALARM_CONTROLLER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IAC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IAC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/iac_pkg.sv -----
// ----------------------------------------------------------------------------
// Intrusion alarm controller package
// Mode codes, register indexes, configuration and result types.
// ----------------------------------------------------------------------------
package iac_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_OFF_HOLD    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ARM_DELAY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ARM_HALF    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ARM_CYCLES  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_HALF   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_CYCLES = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SOUND_HALF  = 3'd6;

    localparam logic [15:0] RST_OFF_HOLD    = 16'd2000;
    localparam logic [15:0] RST_ARM_DELAY   = 16'd1000;
    localparam logic [15:0] RST_ARM_HALF    = 16'd500;
    localparam logic [7:0]  RST_ARM_CYCLES  = 8'd10;
    localparam logic [15:0] RST_TRIG_HALF   = 16'd1000;
    localparam logic [7:0]  RST_TRIG_CYCLES = 8'd5;
    localparam logic [15:0] RST_SOUND_HALF  = 16'd2000;

    typedef enum logic [2:0] {
        MODE_HOLD   = 3'd0,
        MODE_WAIT   = 3'd1,
        MODE_DELAY  = 3'd2,
        MODE_ARMING = 3'd3,
        MODE_ARMED  = 3'd4,
        MODE_TRIG   = 3'd5,
        MODE_SOUND  = 3'd6
    } mode_t;

    typedef struct packed {
        logic [15:0] off_hold_ticks;
        logic [15:0] arm_delay_ticks;
        logic [15:0] arm_half_ticks;
        logic [7:0]  arm_cycles;
        logic [15:0] trig_half_ticks;
        logic [7:0]  trig_cycles;
        logic [15:0] sound_half_ticks;
    } cfg_t;

    typedef struct packed {
        logic       status_led;
        logic       armed_led;
        logic       siren_on;
        logic       notify_pulse;
        logic [2:0] mode_now;
    } result_t;

endpackage

// ----- rtl/core/iac_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Intrusion alarm configuration registers
// Seven timing registers written through a plain index/data write port.
// ----------------------------------------------------------------------------
module iac_cfg_regs
    import iac_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_OFF_HOLD:    cfg_next.off_hold_ticks   = cfg_data;
                CFG_ARM_DELAY:   cfg_next.arm_delay_ticks  = cfg_data;
                CFG_ARM_HALF:    cfg_next.arm_half_ticks   = cfg_data;
                CFG_ARM_CYCLES:  cfg_next.arm_cycles       = cfg_data[7:0];
                CFG_TRIG_HALF:   cfg_next.trig_half_ticks  = cfg_data;
                CFG_TRIG_CYCLES: cfg_next.trig_cycles      = cfg_data[7:0];
                CFG_SOUND_HALF:  cfg_next.sound_half_ticks = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.off_hold_ticks   <= RST_OFF_HOLD;
            cfg_reg.arm_delay_ticks  <= RST_ARM_DELAY;
            cfg_reg.arm_half_ticks   <= RST_ARM_HALF;
            cfg_reg.arm_cycles       <= RST_ARM_CYCLES;
            cfg_reg.trig_half_ticks  <= RST_TRIG_HALF;
            cfg_reg.trig_cycles      <= RST_TRIG_CYCLES;
            cfg_reg.sound_half_ticks <= RST_SOUND_HALF;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/core/iac_fsm.sv -----
// ----------------------------------------------------------------------------
// Intrusion alarm mode sequencer
// Mode, tick, cycle and phase registers advanced once per accepted tick.
// ----------------------------------------------------------------------------
`include "intrusion_alarm_controller_defines.svh"

module iac_fsm
    import iac_pkg::*;
#(
    parameter int TIMER_BITS = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  logic    button_pressed,
    input  logic    motion_seen,
    input  cfg_t    cfg,
    output result_t res
);

    localparam int CW = (TIMER_BITS > 16) ? TIMER_BITS : 16;

    mode_t                 mode_reg;
    mode_t                 mode_next;
    logic [TIMER_BITS-1:0] tick_reg;
    logic [TIMER_BITS-1:0] tick_next;
    logic [7:0]            cycle_reg;
    logic [7:0]            cycle_next;
    logic                  phase_reg;
    logic                  phase_next;

    logic [TIMER_BITS-1:0] tick_sat;
    logic                  tick_full;
    logic [15:0]           win_len;
    logic                  win_done;
    logic [7:0]            cycle_inc;
    logic [7:0]            cycle_lim;
    logic                  cycle_done;
    logic                  blink_done;
    logic                  notify;

    // Saturating window counter: a window ends when the incremented count
    // reaches its length or the counter is full.
    assign tick_full = &tick_reg;
    assign tick_sat  = tick_full ? tick_reg : tick_reg + 1'b1;
    assign win_done  = (CW'(tick_sat) >= CW'(win_len)) || (&tick_sat);

    assign cycle_inc  = cycle_reg + 8'd1;
    assign cycle_done = (cycle_inc >= cycle_lim) || (cycle_inc == 8'd0);
    // The last cycle ends only at the close of an off half.
    assign blink_done = win_done && !phase_reg && cycle_done;

    always_comb
    begin
        unique case (mode_reg)
            MODE_DELAY:  win_len = cfg.arm_delay_ticks;
            MODE_ARMING: win_len = cfg.arm_half_ticks;
            MODE_TRIG:   win_len = cfg.trig_half_ticks;
            MODE_SOUND:  win_len = cfg.sound_half_ticks;
            default:     win_len = cfg.off_hold_ticks;
        endcase
        cycle_lim = (mode_reg == MODE_TRIG) ? cfg.trig_cycles : cfg.arm_cycles;
    end

    always_comb
    begin
        mode_next  = mode_reg;
        tick_next  = tick_reg;
        cycle_next = cycle_reg;
        phase_next = phase_reg;
        notify     = 1'b0;

        unique case (mode_reg)
            MODE_HOLD:
            begin
                tick_next = win_done ? '0 : tick_sat;
                if (win_done)
                begin
                    mode_next = MODE_WAIT;
                end
            end
            MODE_WAIT:
            begin
                if (button_pressed)
                begin
                    mode_next = MODE_DELAY;
                end
            end
            MODE_DELAY:
            begin
                tick_next = win_done ? '0 : tick_sat;
                if (win_done)
                begin
                    mode_next = MODE_ARMING;
                end
            end
            MODE_ARMING, MODE_TRIG:
            begin
                if (button_pressed)
                begin
                    mode_next = MODE_HOLD;
                end
                else if (blink_done)
                begin
                    mode_next = (mode_reg == MODE_TRIG) ? MODE_SOUND : MODE_ARMED;
                    notify    = (mode_reg == MODE_TRIG);
                end
                else
                begin
                    tick_next = win_done ? '0 : tick_sat;
                    if (win_done)
                    begin
                        phase_next = !phase_reg;
                        if (!phase_reg)
                        begin
                            cycle_next = cycle_inc;
                        end
                    end
                end
            end
            MODE_ARMED:
            begin
                if (motion_seen)
                begin
                    mode_next = MODE_TRIG;
                end
                else if (button_pressed)
                begin
                    mode_next = MODE_HOLD;
                end
            end
            MODE_SOUND:
            begin
                if (button_pressed)
                begin
                    mode_next = MODE_HOLD;
                end
                else
                begin
                    tick_next = win_done ? '0 : tick_sat;
                    if (win_done)
                    begin
                        phase_next = !phase_reg;
                    end
                end
            end
            default:
            begin
                mode_next = MODE_HOLD;
            end
        endcase

        // Every mode change starts the new mode with cleared counters.
        if (mode_next != mode_reg)
        begin
            tick_next  = '0;
            cycle_next = 8'd0;
            phase_next = 1'b1;
        end
    end

    always_comb
    begin
        res.notify_pulse = notify;
        res.mode_now     = mode_next;
        unique case (mode_next)
            MODE_ARMING:
            begin
                res.status_led = phase_next;
                res.armed_led  = 1'b0;
                res.siren_on   = 1'b0;
            end
            MODE_ARMED:
            begin
                res.status_led = 1'b0;
                res.armed_led  = 1'b1;
                res.siren_on   = 1'b0;
            end
            MODE_TRIG:
            begin
                res.status_led = phase_next;
                res.armed_led  = phase_next;
                res.siren_on   = 1'b0;
            end
            MODE_SOUND:
            begin
                res.status_led = phase_next;
                res.armed_led  = phase_next;
                res.siren_on   = phase_next;
            end
            default:
            begin
                res.status_led = 1'b1;
                res.armed_led  = 1'b0;
                res.siren_on   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_HOLD;
            tick_reg  <= '0;
            cycle_reg <= 8'd0;
            phase_reg <= 1'b1;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            tick_reg  <= tick_next;
            cycle_reg <= cycle_next;
            phase_reg <= phase_next;
        end
    end

    `IAC_ASSERT_SAME(a_notify_from_trig, step && res.notify_pulse, mode_reg == MODE_TRIG,
        "notify raised outside the triggered mode")
    `IAC_ASSERT_SAME(a_cycles_in_blink, cycle_reg != 8'd0,
        mode_reg == MODE_ARMING || mode_reg == MODE_TRIG,
        "cycle count left set outside a blink mode")
    `IAC_ASSERT_SAME(a_phase_off_modes, !phase_reg,
        mode_reg == MODE_ARMING || mode_reg == MODE_TRIG || mode_reg == MODE_SOUND,
        "off half outside a blinking mode")

endmodule

// ----- rtl/core/iac_out_buf.sv -----
// ----------------------------------------------------------------------------
// Intrusion alarm result buffer
// Output register with a skid entry so a new tick is taken while one waits.
// ----------------------------------------------------------------------------
`include "intrusion_alarm_controller_defines.svh"

module iac_out_buf
    import iac_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    space,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    main_valid_reg;
    logic    main_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t main_reg;
    result_t main_next;
    result_t skid_reg;
    result_t skid_next;
    logic    pop;

    assign pop = main_valid_reg && out_ready;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_next = skid_reg;
                if (push)
                begin
                    skid_next = push_data;
                end
                else
                begin
                    skid_valid_next = 1'b0;
                end
            end
            else if (push)
            begin
                main_next = push_data;
            end
            else
            begin
                main_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg)
            begin
                main_next       = push_data;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign space     = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    `IAC_ASSERT_SAME(a_skid_behind_main, skid_valid_reg, main_valid_reg,
        "skid entry held while the output register is empty")
    `IAC_ASSERT_NEXT(a_stall_fills_skid, main_valid_reg && !out_ready && push,
        skid_valid_reg, "stalled result lost on a new transfer")

endmodule

// ----- rtl/core/intrusion_alarm_controller.sv -----
// ----------------------------------------------------------------------------
// Intrusion alarm controller
// Seven-mode arming, warning and siren sequencer run on timebase ticks.
// ----------------------------------------------------------------------------
//  Channel   Signals                                  Transfer when
//  input     in_valid, in_ready, button_pressed,      in_valid && in_ready
//            motion_seen
//  output    out_valid, out_ready, status_led,        out_valid && out_ready
//            armed_led, siren_on, notify_pulse, mode_now
//  config    cfg_we, cfg_index, cfg_data              cfg_we
//
//  One tick per cycle while in_ready is high: the mode update is a single
//  pass of compare logic from the state registers into the output register,
//  or into the skid entry while the output register holds a stalled result.
//  The output register and a skid entry keep in_ready high for one stalled
//  result; in_ready drops only when both hold results.
//  Reset puts the block in off hold with cleared counters and default
//  timing registers; there is no clearing pass.
// ----------------------------------------------------------------------------
module intrusion_alarm_controller
    import iac_pkg::*;
#(
    parameter int TIMER_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  button_pressed,
    input  logic                  motion_seen,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  status_led,
    output logic                  armed_led,
    output logic                  siren_on,
    output logic                  notify_pulse,
    output logic [2:0]            mode_now,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg;
    result_t step_res;
    result_t out_res;
    logic    space;
    logic    in_fire;

    assign in_ready = space;
    assign in_fire  = in_valid && space;

    iac_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    iac_fsm #(
        .TIMER_BITS (TIMER_BITS)
    ) u_fsm (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (in_fire),
        .button_pressed (button_pressed),
        .motion_seen    (motion_seen),
        .cfg            (cfg),
        .res            (step_res)
    );

    iac_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_fire),
        .push_data (step_res),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_res)
    );

    assign status_led   = out_res.status_led;
    assign armed_led    = out_res.armed_led;
    assign siren_on     = out_res.siren_on;
    assign notify_pulse = out_res.notify_pulse;
    assign mode_now     = out_res.mode_now;

endmodule
